// ----- hw/rtl/second_order_lag_filter_top_defines.svh -----
// Assertion macros for the second-order lag filter.
`ifndef SECOND_ORDER_LAG_FILTER_TOP_DEFINES_SVH
`define SECOND_ORDER_LAG_FILTER_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SOF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("second_order_lag_filter: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define SOF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("second_order_lag_filter: next-cycle check failed");

`endif

// ----- hw/rtl/sof_pkg.sv -----
// Shared types and constants of the second-order lag filter.
package sof_pkg;

  // Scaled accumulator width; all products and sums wrap at this width.
  localparam int WORD_W = 32;
  // Coefficient register width.
  localparam int COEF_W = 9;
  // Configuration register index width.
  localparam int CFG_INDEX_W = 3;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_OLDER_OUTPUT   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_LAST_OUTPUT    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_OLDER_SAMPLE   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_LAST_SAMPLE    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_CURRENT_SAMPLE = 3'd4;

  // Reset weight of the current sample (unity gain in Q.8).
  localparam logic [COEF_W-1:0] COEF_CURRENT_RESET = 9'd256;

  // Request commands.
  localparam logic CMD_FILTER = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  // Coefficient set handed from the register bank to the datapath.
  typedef struct packed {
    logic [COEF_W-1:0] older_output;
    logic [COEF_W-1:0] last_output;
    logic [COEF_W-1:0] older_sample;
    logic [COEF_W-1:0] last_sample;
    logic [COEF_W-1:0] current_sample;
  } coef_t;

endpackage

// ----- hw/rtl/sof_cfg.sv -----
// Coefficient register bank of the second-order lag filter.
module sof_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [sof_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [sof_pkg::COEF_W-1:0]       cfg_data,
  output sof_pkg::coef_t                   coef
);
  import sof_pkg::*;

  // Write one coefficient per enabled cycle; drop writes to unknown indexes.
  always_ff @(posedge clk) begin
    if (rst) begin
      coef.older_output   <= '0;
      coef.last_output    <= '0;
      coef.older_sample   <= '0;
      coef.last_sample    <= '0;
      coef.current_sample <= COEF_CURRENT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_COEF_OLDER_OUTPUT:   coef.older_output   <= cfg_data;
        REG_COEF_LAST_OUTPUT:    coef.last_output    <= cfg_data;
        REG_COEF_OLDER_SAMPLE:   coef.older_sample   <= cfg_data;
        REG_COEF_LAST_SAMPLE:    coef.last_sample    <= cfg_data;
        REG_COEF_CURRENT_SAMPLE: coef.current_sample <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/sof_core.sv -----
// Filter datapath: history registers, five-term sum, overshoot clamp, rounding.
module sof_core #(
  parameter int SAMPLE_BITS   = 16,
  parameter int FRACTION_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   advance,
  input  logic                   command,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  sof_pkg::coef_t         coef,
  output logic [SAMPLE_BITS-1:0] filtered_next
);
  import sof_pkg::*;

  localparam logic [WORD_W-1:0] HALF = WORD_W'(1) << (FRACTION_BITS - 1);

  // History registers, Q.8 outputs and raw samples.
  logic [WORD_W-1:0]      last_output;
  logic [WORD_W-1:0]      older_output;
  logic [SAMPLE_BITS-1:0] last_sample;
  logic [SAMPLE_BITS-1:0] older_sample;

  logic [WORD_W-1:0]      prod_older_out;
  logic [WORD_W-1:0]      prod_last_out;
  logic [WORD_W-1:0]      prod_older_smp;
  logic [WORD_W-1:0]      prod_last_smp;
  logic [WORD_W-1:0]      prod_cur_smp;
  logic [WORD_W-1:0]      biased_older_out;
  logic [WORD_W-1:0]      biased_last_out;
  logic [WORD_W-1:0]      term_older_out;
  logic [WORD_W-1:0]      term_last_out;
  logic [WORD_W-1:0]      scaled_in;
  logic [WORD_W-1:0]      sum;
  logic [WORD_W-1:0]      output_next;
  logic [WORD_W-1:0]      biased_output;
  logic [WORD_W-1:0]      rounded_output;

  // Five products, each wrapped at the accumulator width.
  always_comb begin
    prod_older_out = WORD_W'(coef.older_output)   * older_output;
    prod_last_out  = WORD_W'(coef.last_output)    * last_output;
    prod_older_smp = WORD_W'(coef.older_sample)   * WORD_W'(older_sample);
    prod_last_smp  = WORD_W'(coef.last_sample)    * WORD_W'(last_sample);
    prod_cur_smp   = WORD_W'(coef.current_sample) * WORD_W'(sample);
  end

  // Round the past-output terms back to Q.8, add all five terms, wrap.
  always_comb begin
    biased_older_out = prod_older_out + HALF;
    biased_last_out  = prod_last_out + HALF;
    term_older_out   = biased_older_out >> FRACTION_BITS;
    term_last_out    = biased_last_out >> FRACTION_BITS;
    sum = term_older_out + term_last_out + prod_older_smp
        + prod_last_smp + prod_cur_smp;
  end

  // Clamp an overshoot past a rising scaled input, then round to sample scale; a clear gives zero.
  always_comb begin
    scaled_in = WORD_W'(sample) << FRACTION_BITS;
    if ((last_output < scaled_in) && (sum > scaled_in)) begin
      output_next = scaled_in;
    end else begin
      output_next = sum;
    end
    biased_output  = output_next + HALF;
    rounded_output = biased_output >> FRACTION_BITS;
    if (command == CMD_CLEAR) begin
      filtered_next = '0;
    end else begin
      filtered_next = rounded_output[SAMPLE_BITS-1:0];
    end
  end

  // Advance the history on each request; clear zeroes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_output  <= '0;
      older_output <= '0;
      last_sample  <= '0;
      older_sample <= '0;
    end else if (advance) begin
      if (command == CMD_CLEAR) begin
        last_output  <= '0;
        older_output <= '0;
        last_sample  <= '0;
        older_sample <= '0;
      end else begin
        last_output  <= output_next;
        older_output <= last_output;
        last_sample  <= sample;
        older_sample <= last_sample;
      end
    end
  end

endmodule

// ----- hw/rtl/second_order_lag_filter_top.sv -----
// Second-order lag filter top level: request register, datapath, result register.
//
//   channel   valid          stall          payload
//   input     sample_valid   sample_stall   command, sample
//   output    result_valid   result_stall   filtered
//   config    cfg_write      (none)         cfg_index, cfg_data
//
// One request per cycle sustained while result_stall stays low; a request passes
// the request register, then the result register, and result_valid rises as it
// enters the result register, when that register is free.
// The five-term sum feeding the history update is combinational from the request
// and history registers, which sets the clock period through the multipliers and the adder tree.
// Reset (rst, synchronous) clears history and both valid bits and reloads the reset coefficients.
// A stalled result holds; the request register keeps taking requests until
// it is also full, then sample_stall rises.
module second_order_lag_filter_top #(
  parameter int SAMPLE_BITS   = 16,
  parameter int FRACTION_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            sample_valid,
  output logic                            sample_stall,
  input  logic                            command,
  input  logic [SAMPLE_BITS-1:0]          sample,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [SAMPLE_BITS-1:0]          filtered,
  input  logic                            cfg_write,
  input  logic [sof_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sof_pkg::COEF_W-1:0]      cfg_data
);
  import sof_pkg::*;

  `include "second_order_lag_filter_top_defines.svh"

  coef_t                  coef;
  logic                   req_valid;
  logic                   req_command;
  logic [SAMPLE_BITS-1:0] req_sample;
  logic                   advance;
  logic                   accept;
  logic [SAMPLE_BITS-1:0] filtered_next;

  // Coefficient registers.
  sof_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef      (coef)
  );

  // Move the held request on whenever the result register is free or draining.
  assign advance      = req_valid && (!result_valid || !result_stall);
  assign sample_stall = req_valid && !advance;
  assign accept       = sample_valid && !sample_stall;

  // Request register.
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (accept) begin
      req_valid <= 1'b1;
    end else if (advance) begin
      req_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_command <= command;
      req_sample  <= sample;
    end
  end

  // Datapath and filter history.
  sof_core #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .command       (req_command),
    .sample        (req_sample),
    .coef          (coef),
    .filtered_next (filtered_next)
  );

  // Result register: load on advance, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      filtered <= filtered_next;
    end
  end

  // A clear request yields a zero result on the next cycle.
  `SOF_ASSERT_NEXT(a_clear_zero, advance && req_command == CMD_CLEAR, result_valid && filtered == '0)
  // Every advanced request shows up as a valid result.
  `SOF_ASSERT_NEXT(a_adv_result, advance, result_valid)
  // A full request register behind a stalled result must stall the input.
  `SOF_ASSERT_NOW(a_full_stall, req_valid && result_valid && result_stall, sample_stall && !advance)

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the second-order lag filter top level.
module tb;
  import sof_pkg::*;

  localparam int SMP_W = 16;
  localparam int FRAC_BITS = 8;
  localparam logic [WORD_W-1:0] ROUND_HALF = 32'd1 << (FRAC_BITS - 1);
  localparam int SCRIPT_LEN = 44;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 92;
  localparam int SETTLE_CYCLES = 4;
  localparam int CYCLE_LIMIT = 200000;
  localparam int REPORT_LIMIT = 10;

  // Register indexes past the coefficient bank; writes there must be dropped.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef enum logic { ROW_REG, ROW_REQ } row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_INDEX_W-1:0] idx;
    logic [COEF_W-1:0]      data;
    logic                   cmd;
    logic [SMP_W-1:0]       smp;
    logic                   known;
    logic [SMP_W-1:0]       want;
  } row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   sample_valid = 1'b0;
  logic                   sample_stall;
  logic                   command = CMD_FILTER;
  logic [SMP_W-1:0]       sample = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  logic [SMP_W-1:0]       filtered;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [COEF_W-1:0]      cfg_data = '0;

  // Shadow of the coefficient bank and the filter history.
  coef_t             coef_now;
  logic [WORD_W-1:0] out_q8_last;
  logic [WORD_W-1:0] out_q8_older;
  logic [SMP_W-1:0]  smp_last;
  logic [SMP_W-1:0]  smp_older;

  logic [SMP_W-1:0] filtered_due[$];
  int mismatches = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int cycle_count = 0;
  row_t script [0:SCRIPT_LEN-1];

  second_order_lag_filter_top dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .command      (command),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .filtered     (filtered),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Coefficient times history word, wrapped to 32 bits, then rounded back to Q.8.
  function automatic logic [WORD_W-1:0] rounded_term(input logic [COEF_W-1:0] c,
                                                     input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] p;
    p = {{(WORD_W-COEF_W){1'b0}}, c} * v;
    p = p + ROUND_HALF;
    return p >> FRAC_BITS;
  endfunction

  // Advance the shadow filter by one request and return the expected output.
  function automatic logic [SMP_W-1:0] lag_filter_step(input logic cmd,
                                                       input logic [SMP_W-1:0] smp);
    logic [WORD_W-1:0] acc;
    logic [WORD_W-1:0] scaled_in;
    logic [WORD_W-1:0] rounded;
    if (cmd == CMD_CLEAR) begin
      out_q8_last = '0;
      out_q8_older = '0;
      smp_last = '0;
      smp_older = '0;
      return '0;
    end
    scaled_in = {{(WORD_W-SMP_W){1'b0}}, smp} << FRAC_BITS;
    acc = rounded_term(coef_now.older_output, out_q8_older)
        + rounded_term(coef_now.last_output, out_q8_last)
        + {{(WORD_W-COEF_W){1'b0}}, coef_now.older_sample} * {16'd0, smp_older}
        + {{(WORD_W-COEF_W){1'b0}}, coef_now.last_sample} * {16'd0, smp_last}
        + {{(WORD_W-COEF_W){1'b0}}, coef_now.current_sample} * {16'd0, smp};
    // Clamp an overshoot past a rising input.
    if (out_q8_last < scaled_in && acc > scaled_in) acc = scaled_in;
    out_q8_older = out_q8_last;
    out_q8_last = acc;
    smp_older = smp_last;
    smp_last = smp;
    rounded = (acc + ROUND_HALF) >> FRAC_BITS;
    return rounded[SMP_W-1:0];
  endfunction

  function automatic row_t req_row(input logic cmd, input logic [SMP_W-1:0] smp);
    return '{ROW_REQ, '0, '0, cmd, smp, 1'b0, '0};
  endfunction

  function automatic row_t checked_row(input logic cmd, input logic [SMP_W-1:0] smp,
                                       input logic [SMP_W-1:0] want);
    return '{ROW_REQ, '0, '0, cmd, smp, 1'b1, want};
  endfunction

  function automatic row_t reg_row(input logic [CFG_INDEX_W-1:0] idx,
                                   input logic [COEF_W-1:0] data);
    return '{ROW_REG, idx, data, CMD_FILTER, '0, 1'b0, '0};
  endfunction

  // Hand one request to the block, then record what it should produce.
  task automatic send_request(input logic cmd, input logic [SMP_W-1:0] smp,
                              input logic known, input logic [SMP_W-1:0] want);
    logic [SMP_W-1:0] predicted;
    while ($urandom_range(0, 99) < idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    command <= cmd;
    sample <= smp;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    predicted = lag_filter_step(cmd, smp);
    filtered_due.push_back(known ? want : predicted);
  endtask

  // Hold off requests until every result is back and the pipeline is empty.
  task automatic wait_idle();
    sample_valid <= 1'b0;
    while (filtered_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register; the caller drops cfg_write after the last write.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [COEF_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      REG_COEF_OLDER_OUTPUT:   coef_now.older_output = value;
      REG_COEF_LAST_OUTPUT:    coef_now.last_output = value;
      REG_COEF_OLDER_SAMPLE:   coef_now.older_sample = value;
      REG_COEF_LAST_SAMPLE:    coef_now.last_sample = value;
      REG_COEF_CURRENT_SAMPLE: coef_now.current_sample = value;
      default: ;
    endcase
  endtask

  // Pick a coefficient set per phase: unity-gain splits, all-256, all-511, random.
  task automatic load_coefs(input int phase);
    coef_t fresh;
    int left;
    if (phase == 2) begin
      fresh = {5{9'd256}};
    end else if (phase == 5) begin
      fresh = {5{9'h1FF}};
    end else if (phase % 2 == 1) begin
      fresh.older_output = COEF_W'($urandom_range(0, 511));
      fresh.last_output = COEF_W'($urandom_range(0, 511));
      fresh.older_sample = COEF_W'($urandom_range(0, 511));
      fresh.last_sample = COEF_W'($urandom_range(0, 511));
      fresh.current_sample = COEF_W'($urandom_range(0, 511));
    end else begin
      left = 256;
      fresh.older_output = COEF_W'($urandom_range(0, left));
      left -= fresh.older_output;
      fresh.last_output = COEF_W'($urandom_range(0, left));
      left -= fresh.last_output;
      fresh.older_sample = COEF_W'($urandom_range(0, left));
      left -= fresh.older_sample;
      fresh.last_sample = COEF_W'($urandom_range(0, left));
      left -= fresh.last_sample;
      fresh.current_sample = COEF_W'(left);
    end
    if (phase == 4) write_reg(REG_SPARE_LO, COEF_W'($urandom_range(0, 511)));
    write_reg(REG_COEF_OLDER_OUTPUT, fresh.older_output);
    write_reg(REG_COEF_LAST_OUTPUT, fresh.last_output);
    write_reg(REG_COEF_OLDER_SAMPLE, fresh.older_sample);
    write_reg(REG_COEF_LAST_SAMPLE, fresh.last_sample);
    write_reg(REG_COEF_CURRENT_SAMPLE, fresh.current_sample);
    cfg_write <= 1'b0;
  endtask

  // Mostly held step levels (lag responses), some noise and occasional clears.
  task automatic run_phase(input int phase);
    int n;
    int pick;
    int run_left;
    logic cmd;
    logic [SMP_W-1:0] level;
    logic [SMP_W-1:0] smp;
    run_left = 0;
    level = '0;
    for (n = 0; n < PHASE_ITEMS; n++) begin
      if (phase == 3 && n == PHASE_ITEMS / 2) wait_idle();
      cmd = CMD_FILTER;
      smp = SMP_W'($urandom);
      if (run_left == 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
          cmd = CMD_CLEAR;
        end else if (pick >= 30) begin
          level = SMP_W'($urandom);
          run_left = $urandom_range(3, 20);
        end
      end
      if (run_left != 0) begin
        smp = level;
        run_left--;
      end
      send_request(cmd, smp, 1'b0, '0);
    end
  endtask

  // Random backpressure on the result side.
  always @(posedge clk) begin
    result_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin : check_results
    logic [SMP_W-1:0] want;
    if (!rst && result_valid && !result_stall) begin
      if (filtered_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: filtered %04h with no request pending", filtered);
      end else begin
        want = filtered_due.pop_front();
        if (filtered !== want) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("mismatch: filtered expected %04h got %04h", want, filtered);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    int i;
    int phase;
    bit writing;
    coef_now = '0;
    coef_now.current_sample = COEF_CURRENT_RESET;
    out_q8_last = '0;
    out_q8_older = '0;
    smp_last = '0;
    smp_older = '0;
    writing = 1'b0;

    script = '{
      // reset coefficients pass the sample through
      checked_row(CMD_FILTER, 16'h0000, 16'h0000),
      checked_row(CMD_FILTER, 16'hFFFF, 16'hFFFF),
      checked_row(CMD_FILTER, 16'h5555, 16'h5555),
      checked_row(CMD_FILTER, 16'hAAAA, 16'hAAAA),
      checked_row(CMD_CLEAR,  16'hFFFF, 16'h0000),
      checked_row(CMD_FILTER, 16'h0001, 16'h0001),
      // all weights zero
      reg_row(REG_COEF_CURRENT_SAMPLE, 9'h000),
      checked_row(CMD_FILTER, 16'h04D2, 16'h0000),
      // heavy current weight overshoots from rest and gets clamped
      reg_row(REG_COEF_CURRENT_SAMPLE, 9'h1FF),
      checked_row(CMD_CLEAR,  16'h0000, 16'h0000),
      checked_row(CMD_FILTER, 16'h0064, 16'h0064),
      req_row(CMD_FILTER, 16'h0032),
      req_row(CMD_FILTER, 16'hFFFF),
      // writes past the bank change nothing
      reg_row(REG_SPARE_LO, 9'h1FF),
      reg_row(REG_SPARE_HI, 9'h0AA),
      req_row(CMD_FILTER, 16'h00C8),
      // every weight at unity (256): results wrap at the sample width
      reg_row(REG_COEF_OLDER_OUTPUT, 9'h100),
      reg_row(REG_COEF_LAST_OUTPUT, 9'h100),
      reg_row(REG_COEF_OLDER_SAMPLE, 9'h100),
      reg_row(REG_COEF_LAST_SAMPLE, 9'h100),
      reg_row(REG_COEF_CURRENT_SAMPLE, 9'h100),
      checked_row(CMD_CLEAR,  16'h1234, 16'h0000),
      req_row(CMD_FILTER, 16'hFFFF),
      req_row(CMD_FILTER, 16'hFFFF),
      req_row(CMD_FILTER, 16'hFFFF),
      req_row(CMD_FILTER, 16'hFFFF),
      // every weight at the register maximum
      reg_row(REG_COEF_OLDER_OUTPUT, 9'h1FF),
      reg_row(REG_COEF_LAST_OUTPUT, 9'h1FF),
      reg_row(REG_COEF_OLDER_SAMPLE, 9'h1FF),
      reg_row(REG_COEF_LAST_SAMPLE, 9'h1FF),
      reg_row(REG_COEF_CURRENT_SAMPLE, 9'h1FF),
      req_row(CMD_FILTER, 16'hFFFF),
      req_row(CMD_FILTER, 16'h8000),
      req_row(CMD_FILTER, 16'h0001),
      // a typical unity-gain lag
      reg_row(REG_COEF_OLDER_OUTPUT, 9'h040),
      reg_row(REG_COEF_LAST_OUTPUT, 9'h080),
      reg_row(REG_COEF_OLDER_SAMPLE, 9'h010),
      reg_row(REG_COEF_LAST_SAMPLE, 9'h010),
      reg_row(REG_COEF_CURRENT_SAMPLE, 9'h020),
      checked_row(CMD_CLEAR,  16'h0000, 16'h0000),
      req_row(CMD_FILTER, 16'h1000),
      req_row(CMD_FILTER, 16'h1000),
      req_row(CMD_FILTER, 16'h0000),
      req_row(CMD_FILTER, 16'hFFFF)
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table; drain before each group of register writes.
    for (i = 0; i < SCRIPT_LEN; i++) begin
      if (script[i].kind == ROW_REG) begin
        if (!writing) wait_idle();
        write_reg(script[i].idx, script[i].data);
        writing = 1'b1;
      end else begin
        if (writing) cfg_write <= 1'b0;
        writing = 1'b0;
        send_request(script[i].cmd, script[i].smp, script[i].known, script[i].want);
      end
    end
    if (writing) cfg_write <= 1'b0;

    // Random phases, each with its own coefficients and idling pattern.
    for (phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      load_coefs(phase);
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 59; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 59; end
        default: begin idle_pct = 23; stall_pct = 23; end
      endcase
      run_phase(phase);
    end

    wait_idle();
    if (filtered_due.size() != 0) begin
      mismatches++;
      $display("%0d results never arrived", filtered_due.size());
    end
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
